// ----- rtl/core/msl_pkg.sv -----
// Package for the maximal length sequence generator.
// Holds the degree limits, the counter width and the tap table.
// No dependencies.
package msl_pkg;

    // Largest register length that the tap table covers.
    localparam int C_MAX_DEGREE = 11;
    localparam int C_MIN_DEGREE = 2;

    // Width of the degree register and of the tap masks.
    localparam int C_DEGREE_W = 4;
    localparam int C_TAP_W    = 11;

    // Width of the per-run bit counter.
    localparam int C_COUNT_W = 11;

    // Degree after reset.
    localparam logic [C_DEGREE_W-1:0] C_DEGREE_RESET = 4'd8;

    // Tapped cells for one degree, cell 0 included.
    function automatic logic [C_TAP_W-1:0] tap_mask(input logic [C_DEGREE_W-1:0] degree);
        logic [C_TAP_W-1:0] mask;
        case (degree)
            4'd2:    mask = 11'h003;
            4'd3:    mask = 11'h005;
            4'd4:    mask = 11'h009;
            4'd5:    mask = 11'h009;
            4'd6:    mask = 11'h021;
            4'd7:    mask = 11'h041;
            4'd8:    mask = 11'h071;
            4'd9:    mask = 11'h021;
            4'd10:   mask = 11'h081;
            4'd11:   mask = 11'h201;
            default: mask = 11'h000;
        endcase
        return mask;
    endfunction

endpackage

// ----- rtl/core/m_sequence_lfsr.sv -----
// Maximal length sequence generator, top level.
// An input transfer's result is in the output register in the next cycle.
// Throughput: one item per cycle unless stalled; cells and counter step together.
// Input stalls only while a finished result waits and the output side stalls.
// Reset (synchronous, active low): cells all ones, count zero, degree 8, no result.
// Depends on msl_pkg.
module m_sequence_lfsr
    import msl_pkg::*;
#(
    parameter int MAX_DEGREE = C_MAX_DEGREE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [C_DEGREE_W-1:0] i_cfg_degree,
    // Input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_restart,
    // Output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_seq_bit,
    output logic                  o_last
);

    localparam int CELL_W = MAX_DEGREE;

    logic [C_DEGREE_W-1:0] r_degree;
    logic [CELL_W-1:0]     r_cells, n_cells;
    logic [C_COUNT_W-1:0]  r_count, n_count;
    logic                  r_out_valid;
    logic                  r_seq_bit, n_seq_bit;
    logic                  r_last, n_last;

    logic                  in_xfer;
    logic                  out_free;
    logic [CELL_W-1:0]     start_cells;
    logic [C_COUNT_W-1:0]  start_count;
    logic [CELL_W:0]       cells_ext;
    logic [CELL_W-1:0]     shifted;
    logic [C_TAP_W-1:0]    taps;
    logic [C_COUNT_W:0]    run_len;
    logic [C_COUNT_W:0]    count_inc;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !out_free;
    assign in_xfer     = i_in_valid && out_free;

    // Degree register: values outside the supported range are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= C_DEGREE_RESET;
        end else if (i_cfg_valid &&
                     i_cfg_degree >= C_DEGREE_W'(C_MIN_DEGREE) &&
                     i_cfg_degree <= C_DEGREE_W'(MAX_DEGREE)) begin
            r_degree <= i_cfg_degree;
        end
    end

    // One step of the register: restart, feedback, shift and run end.
    always_comb begin
        start_cells = i_restart ? {CELL_W{1'b1}} : r_cells;
        start_count = i_restart ? '0 : r_count;

        taps      = tap_mask(r_degree);
        n_seq_bit = ^(start_cells & taps[CELL_W-1:0]);

        // Cells below degree-1 take their upper neighbor; cells above hold.
        cells_ext = {1'b0, start_cells};
        for (int i = 0; i < CELL_W; i++) begin
            if (i + 1 < int'(r_degree)) begin
                shifted[i] = cells_ext[i+1];
            end else if (i + 1 == int'(r_degree)) begin
                shifted[i] = n_seq_bit;
            end else begin
                shifted[i] = start_cells[i];
            end
        end

        run_len   = (C_COUNT_W+1)'((12'd1 << r_degree) - 12'd1);
        count_inc = {1'b0, start_count} + 1'b1;
        n_last    = (count_inc >= run_len);

        if (n_last) begin
            n_cells = {CELL_W{1'b1}};
            n_count = '0;
        end else begin
            n_cells = shifted;
            n_count = count_inc[C_COUNT_W-1:0];
        end
    end

    // Generator state advances on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells <= {CELL_W{1'b1}};
            r_count <= '0;
        end else if (in_xfer) begin
            r_cells <= n_cells;
            r_count <= n_count;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= in_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_seq_bit <= n_seq_bit;
            r_last    <= n_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_seq_bit   = r_seq_bit;
    assign o_last      = r_last;

endmodule

// ----- rtl/core/msl_checker.sv -----
// Port-level checker for the sequence generator, bound to the top level.
// Depends on msl_pkg and m_sequence_lfsr.
module msl_checker
    import msl_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic i_restart,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_seq_bit,
    input logic o_last
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_seq_bit) && $stable(o_last))
        else $error("stalled result changed");

    // The input side stalls only behind a waiting result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a waiting result");

    // Every input transfer yields a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("input transfer produced no result");

    // From all ones every tap set has even parity, and no run ends on its first bit.
    a_restart_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_restart |=> !o_seq_bit && !o_last)
        else $error("wrong first bit after restart");

endmodule

bind m_sequence_lfsr msl_checker u_msl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_restart   (i_restart),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_seq_bit   (o_seq_bit),
    .o_last      (o_last)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the maximal length sequence generator m_sequence_lfsr.
// Predicts every sequence bit and run end, and checks them against the block.
// Depends on msl_pkg and the m_sequence_lfsr RTL.
module tb;
    import msl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;

    // Feedback cells per degree, cell 0 included.
    localparam logic [C_TAP_W-1:0] FEEDBACK_TAPS [2:11] = '{
        11'b000_0000_0011, 11'b000_0000_0101, 11'b000_0000_1001, 11'b000_0000_1001,
        11'b000_0010_0001, 11'b000_0100_0001, 11'b000_0111_0001, 11'b000_0010_0001,
        11'b000_1000_0001, 11'b010_0000_0001
    };

    typedef struct packed {
        logic seq_bit;
        logic last;
    } t_seq_result;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_valid  = 1'b0;
    logic                  o_cfg_ready;
    logic [C_DEGREE_W-1:0] i_cfg_degree = '0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_stall;
    logic                  i_restart    = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall  = 1'b0;
    logic                  o_seq_bit;
    logic                  o_last;

    // Predicted state of the generator.
    logic [C_TAP_W-1:0]    lfsr_cells  = '1;
    logic [C_COUNT_W-1:0]  run_count   = '0;
    logic [C_DEGREE_W-1:0] cur_degree  = C_DEGREE_RESET;

    logic        pending_restarts[$];
    t_seq_result expected_bits[$];

    logic in_taken       = 1'b0;
    int   send_idle_pct  = 0;
    int   recv_idle_pct  = 0;
    int   hold_requests  = 0;
    int   hold_served    = 0;
    int   hold_cnt       = 0;

    int   error_count    = 0;
    int   items_queued   = 0;
    int   results_seen   = 0;
    int   run_ends_seen  = 0;
    int   in_stall_cycles = 0;
    int   cfg_writes     = 0;
    int   cycle_count    = 0;

    m_sequence_lfsr dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_degree (i_cfg_degree),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_restart    (i_restart),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_seq_bit    (o_seq_bit),
        .o_last       (o_last)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Advances the predicted generator by one bit and returns that bit and its run flag.
    task automatic advance_sequence(input logic restart, output t_seq_result res);
        int   deg;
        int   low_mask;
        int   run_len;
        logic fb;
        deg = int'(cur_degree);
        if (restart) begin
            lfsr_cells = '1;
            run_count  = '0;
        end
        fb       = ^(lfsr_cells & FEEDBACK_TAPS[deg]);
        low_mask = (1 << deg) - 1;
        run_len  = low_mask;
        // Only the low deg cells shift; cells above keep their values.
        lfsr_cells = (lfsr_cells & ~low_mask[C_TAP_W-1:0])
                   | ((lfsr_cells & low_mask[C_TAP_W-1:0]) >> 1)
                   | (C_TAP_W'(fb) << (deg - 1));
        res.seq_bit = fb;
        res.last    = (int'(run_count) + 1 >= run_len);
        if (res.last) begin
            lfsr_cells = '1;
            run_count  = '0;
        end else begin
            run_count = run_count + 1'b1;
        end
    endtask

    // Input transfers feed the predictor; output transfers are checked against it.
    always @(posedge i_clk) begin
        t_seq_result want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else if (i_rst_n) begin
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && o_in_stall) begin
                in_stall_cycles <= in_stall_cycles + 1;
            end
            if (o_out_valid && !i_out_stall) begin
                results_seen <= results_seen + 1;
                if (expected_bits.size() == 0) begin
                    $display("%0t: result with nothing expected: seq_bit %0b last %0b",
                             $time, o_seq_bit, o_last);
                    error_count = error_count + 1;
                end else begin
                    want = expected_bits.pop_front();
                    if (want.last) begin
                        run_ends_seen <= run_ends_seen + 1;
                    end
                    if (o_seq_bit !== want.seq_bit) begin
                        $display("%0t: seq_bit mismatch: expected %0b actual %0b",
                                 $time, want.seq_bit, o_seq_bit);
                        error_count = error_count + 1;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t: last mismatch: expected %0b actual %0b",
                                 $time, want.last, o_last);
                        error_count = error_count + 1;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                advance_sequence(i_restart, want);
                expected_bits.push_back(want);
            end
        end
    end

    // Sender: offers queued items, holding each one until its transfer.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_restart  <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_restarts.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_restart  <= pending_restarts.pop_front();
            end else begin
                i_in_valid <= 1'b0;
                i_restart  <= 1'($urandom);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_cnt    <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt    <= hold_cnt - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Waits until every queued item went through and every result came back.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_restarts.size() != 0 || i_in_valid || expected_bits.size() != 0);
        repeat (2) @(negedge i_clk);
    endtask

    // Writes the degree register while the block is idle.
    task automatic set_degree(input logic [C_DEGREE_W-1:0] value);
        wait_drained();
        i_cfg_valid  <= 1'b1;
        i_cfg_degree <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        // Values outside the tap table leave the degree as it was.
        if (value >= C_MIN_DEGREE && value <= C_MAX_DEGREE) begin
            cur_degree = value;
        end
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid  <= 1'b0;
        i_cfg_degree <= C_DEGREE_W'($urandom);
    endtask

    // Queues a number of bits, each a restart with the given chance in percent.
    task automatic queue_bits(input int count, input int restart_pct);
        for (int n = 0; n < count; n++) begin
            pending_restarts.push_back($urandom_range(99) < restart_pct);
        end
        items_queued += count;
    endtask

    // Stimulus sequence.
    initial begin
        logic [C_DEGREE_W-1:0] pick;
        int                    phase_end;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 7;
        recv_idle_pct = 60;

        // Reset degree, with a restart in the middle of a run.
        pending_restarts = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
        items_queued += 6;

        // Out-of-range degrees are rejected and the run goes on at degree 8.
        set_degree(4'd0);
        set_degree(4'd15);
        set_degree(4'd1);
        set_degree(4'd12);
        queue_bits(2, 0);

        // Shortest runs: the run end reloads, and so does a restart.
        set_degree(4'd2);
        pending_restarts = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
        items_queued += 5;

        // Eleven bits at degree 11 leave cells 0 and 1 at zero; dropping to
        // degree 2 then yields a zero bit that is already past the run end.
        set_degree(4'd11);
        pending_restarts.push_back(1'b1);
        queue_bits(10, 0);
        items_queued += 1;
        set_degree(4'd2);
        queue_bits(2, 0);

        // Random part in three idling modes.
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 7 : (mode == 1) ? 60 : 0;
            recv_idle_pct = (mode == 0) ? 60 : (mode == 1) ? 7 : 0;
            phase_end     = items_queued + 120;
            if (mode == 2) begin
                // Long receiver hold-off while the sender keeps offering.
                set_degree(4'd5);
                queue_bits(40, 3);
                @(posedge i_clk);
                hold_requests++;
            end
            while (items_queued < phase_end) begin
                pick = ($urandom_range(9) < 7) ? C_DEGREE_W'($urandom_range(7, 2))
                                               : C_DEGREE_W'($urandom_range(15, 0));
                if ($urandom_range(3) != 0) begin
                    set_degree(pick);
                end
                if ($urandom_range(9) == 0) begin
                    queue_bits($urandom_range(12, 1), 50);
                end else begin
                    queue_bits($urandom_range(40, 1), 3);
                end
            end
        end

        // One full run at the reset degree, and a few bits into the next one.
        set_degree(4'd8);
        pending_restarts.push_back(1'b1);
        items_queued += 1;
        queue_bits(258, 0);

        wait_drained();
        repeat (5) @(posedge i_clk);
        $display("Covered %0d input bits, %0d checked results, %0d run ends, %0d degree writes,",
                 items_queued, results_seen, run_ends_seen, cfg_writes);
        $display("and %0d cycles in which the input was held back by the block.",
                 in_stall_cycles);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
